### sv/bmts_pkg.sv
package bmts_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int VTX_CAP          = 32;
    localparam int VC_W             = 6;
    localparam int VTX_W            = 5;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 8;
    localparam logic [VC_W-1:0] VC_RESET = 6'd32;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_SORT = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VTX_W-1:0] from_vertex;
        logic [VTX_W-1:0] to_vertex;
    } cmd_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_index;
        logic             cycle_found;
        logic             last_result;
    } result_t;

    // number of vertices actually held in the matrix
    function automatic int nv_of(int max_vertices);
        return (max_vertices < VTX_CAP) ? max_vertices : VTX_CAP;
    endfunction

endpackage

### sv/bmts_front.sv
module bmts_front #(
    parameter int CW = 6
) (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [9:0]        s_tdata,   // from_vertex [4:0], to_vertex [9:5]
    input  logic              s_tuser,   // opcode
    input  logic [CW-1:0]     active_n,
    input  logic              q_full,
    output logic              q_push,
    output bmts_pkg::cmd_t    q_cmd
);
    import bmts_pkg::*;

    op_t              op;
    logic [VTX_W-1:0] from_v;
    logic [VTX_W-1:0] to_v;
    logic             in_range;

    assign op     = op_t'(s_tuser);
    assign from_v = s_tdata[VTX_W-1:0];
    assign to_v   = s_tdata[2*VTX_W-1:VTX_W];

    // out-of-range edges are dropped here and never reach the queue
    assign in_range = (VC_W'(from_v) < VC_W'(active_n)) && (VC_W'(to_v) < VC_W'(active_n));

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && ((op == OP_SORT) || in_range);
    assign q_cmd    = '{op: op, from_vertex: from_v, to_vertex: to_v};

endmodule

### sv/bmts_fifo.sv
module bmts_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bmts_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output bmts_pkg::cmd_t head
);
    import bmts_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/bmts_back.sv
module bmts_back #(
    parameter int MAX_VERTICES = bmts_pkg::MAX_VERTICES_DEF,
    parameter int CW           = $clog2(bmts_pkg::nv_of(MAX_VERTICES) + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CW-1:0]     active_n,
    input  logic              q_empty,
    input  bmts_pkg::cmd_t    q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output bmts_pkg::result_t m_res
);
    import bmts_pkg::*;

    localparam int NV = nv_of(MAX_VERTICES);
    localparam int IW = $clog2(NV);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_CYCLE,
        ST_CLEAR
    } state_t;

    state_t          state_reg;
    logic [NV-1:0]   rows_reg [NV];
    logic [NV-1:0]   used_reg;
    logic [NV-1:0]   src_reg;
    logic [NV-1:0]   inc_reg;
    logic [IW-1:0]   idx_reg;
    logic            final_reg;
    logic            out_valid_reg;
    result_t         out_reg;

    logic [NV-1:0]   all_mask;
    logic [NV-1:0]   inc_full;
    logic [NV-1:0]   src_new;
    logic [NV-1:0]   src_rest;
    logic            last_idx;
    logic            slot_free;
    logic            emit_now;

    always_comb begin
        for (int i = 0; i < NV; i++) begin
            all_mask[i] = (CW'(i) < active_n);
        end
    end

    assign inc_full  = inc_reg | rows_reg[idx_reg];
    assign src_new   = ~inc_full & ~used_reg & all_mask;
    assign src_rest  = src_reg & ~(NV'(1) << idx_reg);
    assign last_idx  = (CW'(idx_reg) == active_n - CW'(1));
    assign slot_free = !out_valid_reg || m_ready;
    assign emit_now  = slot_free && (((state_reg == ST_EMIT) && src_reg[idx_reg])
                                     || (state_reg == ST_CYCLE));
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid   = out_valid_reg;
    assign m_res     = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NV; i++) begin
                rows_reg[i] <= '0;
            end
            used_reg      <= '0;
            src_reg       <= '0;
            inc_reg       <= '0;
            idx_reg       <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            if (emit_now) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        if (q_head.op == OP_EDGE) begin
                            rows_reg[q_head.from_vertex[IW-1:0]][q_head.to_vertex[IW-1:0]] <= 1'b1;
                        end else begin
                            idx_reg   <= '0;
                            inc_reg   <= '0;
                            used_reg  <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (last_idx) begin
                        if (src_new == '0) begin
                            state_reg <= ST_CYCLE;
                        end else begin
                            src_reg   <= src_new;
                            used_reg  <= used_reg | src_new;
                            final_reg <= ((used_reg | src_new) == all_mask);
                            idx_reg   <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end else begin
                        inc_reg <= inc_full;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (src_reg[idx_reg]) begin
                        if (slot_free) begin
                            out_reg           <= '{vertex_index: VTX_W'(idx_reg),
                                                   cycle_found:  1'b0,
                                                   last_result:  final_reg && (src_rest == '0)};
                            rows_reg[idx_reg] <= '0;
                            src_reg           <= src_rest;
                            if (src_rest == '0) begin
                                if (final_reg) begin
                                    state_reg <= ST_CLEAR;
                                end else begin
                                    idx_reg   <= '0;
                                    inc_reg   <= '0;
                                    state_reg <= ST_SCAN;
                                end
                            end else begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_CYCLE: begin
                    if (slot_free) begin
                        out_reg       <= '{vertex_index: '0, cycle_found: 1'b1,
                                           last_result: 1'b1};
                        state_reg     <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    for (int i = 0; i < NV; i++) begin
                        rows_reg[i] <= '0;
                    end
                    used_reg  <= '0;
                    src_reg   <= '0;
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/bit_matrix_topological_sort.sv
// Edge load: one transfer per cycle while the queue is not full; the edge goes into the queue,
// then into the matrix when the idle back end pops it. Sort: per layer, the rows are ORed one
// row per cycle, then indices are walked up to the layer's highest source, each source emitted
// once the output slot is free; a layer with no source gives a cycle result. The matrix is then
// cleared. The first vertex comes after the pop and first scan; input stalls once the queue fills.
// Reset (aresetn low, synchronous): matrix and queue empty, vertex_count = 32, no output.
module bit_matrix_topological_sort #(
    parameter int MAX_VERTICES = bmts_pkg::MAX_VERTICES_DEF,
    parameter int QUEUE_DEPTH  = bmts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bmts_pkg::VC_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bmts_pkg::S_TDATA_W-1:0] s_tdata,   // from_vertex [4:0], to_vertex [9:5]
    input  logic                           s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bmts_pkg::M_TDATA_W-1:0] m_tdata,   // vertex_index [4:0]
    output logic                           m_tuser,   // cycle_found
    output logic                           m_tlast    // last_result
);
    import bmts_pkg::*;

    localparam int NV = nv_of(MAX_VERTICES);
    localparam int CW = $clog2(NV + 1);

    logic [VC_W-1:0] vc_reg;
    logic [CW-1:0]   active_n;
    logic            q_push, q_pop, q_full, q_empty;
    cmd_t            q_cmd, q_head;
    result_t         res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
        end else if (cfg_we) begin
            vc_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (vc_reg == '0) begin
            active_n = CW'(1);
        end else if (vc_reg > VC_W'(NV)) begin
            active_n = CW'(NV);
        end else begin
            active_n = CW'(vc_reg);
        end
    end

    bmts_front #(.CW(CW)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata[2*VTX_W-1:0]),
        .s_tuser  (s_tuser),
        .active_n (active_n),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    bmts_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    bmts_back #(.MAX_VERTICES(MAX_VERTICES), .CW(CW)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .active_n (active_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {{(M_TDATA_W - VTX_W){1'b0}}, res.vertex_index};
    assign m_tuser = res.cycle_found;
    assign m_tlast = res.last_result;

endmodule

### sv/bmts_checker.sv
module bmts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic [bmts_pkg::VC_W-1:0]      cfg_wdata,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [bmts_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bmts_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);
    import bmts_pkg::*;

    logic [VC_W-1:0] vc_reg;
    logic [VC_W-1:0] n_chk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
        end else if (cfg_we) begin
            vc_reg <= cfg_wdata;
        end
    end

    assign n_chk = (vc_reg == '0) ? VC_W'(1) : vc_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output changed while stalled");

    a_cycle_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("cycle result not final or nonzero index");

    a_vertex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (VC_W'(m_tdata[VTX_W-1:0]) < n_chk))
        else $error("vertex index out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind bit_matrix_topological_sort bmts_checker u_bmts_checker (.*);
